// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the debouncer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PSD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another on the next edge.
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psd_pkg.sv =====
// Types and constants shared by the port switch debouncer modules.
package psd_pkg;

  // Fixed port width of the sampled port.
  localparam int PORT_WIDTH = 8;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_DELAY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PORT_NUMBER  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MASK  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_MASK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_RISE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_FALL    = 3'd5;

  // Reset value of the bounce delay in milliseconds.
  localparam logic [CFG_DATA_W-1:0] BOUNCE_DELAY_RESET = 16'd50;

  // What one lane found for the item being transferred.
  typedef struct packed {
    logic hit;      // a reported debounced edge
    logic level;    // reported level, only set together with hit
    logic stable;   // stable raw level after this update
  } psd_lane_res_t;

endpackage

// ===== rtl/psd_lane.sv =====
// One pin lane: stable and transient level, change time and edge decision.
`include "assert_macros.svh"

module psd_lane
  import psd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  logic                  sample_bit,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [CFG_DATA_W-1:0] bounce_delay,
  input  logic                  invert,
  input  logic                  fast,
  input  logic                  skip_rise,
  input  logic                  skip_fall,
  output psd_lane_res_t         res
);

  logic                 stable;
  logic                 transient;
  logic [TIME_BITS-1:0] change_time;

  logic                 changed;
  logic                 settled;
  logic [TIME_BITS-1:0] elapsed;
  logic                 accept;
  logic                 rep;

  // A non-fast pin restarts its timer on a fresh change, which can never
  // pass the delay check, so only an unchanged transient (or fast mode) may settle.
  always_comb begin
    changed = (sample_bit != transient);
    elapsed = now - change_time;
    settled = (elapsed > TIME_BITS'(bounce_delay));
    accept  = (sample_bit != stable) && (fast || !changed) && settled;
    rep     = sample_bit ^ invert;
    res.hit    = accept && (rep ? !skip_rise : !skip_fall);
    res.level  = accept && rep && !skip_rise;
    res.stable = accept ? sample_bit : stable;
  end

  // Lane state follows the sample on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      transient   <= 1'b0;
      change_time <= '0;
    end else if (update) begin
      stable    <= res.stable;
      transient <= sample_bit;
      if (changed) begin
        change_time <= now;
      end
    end
  end

  `PSD_ASSERT_NEXT(a_transient_tracks, clk, rst, update, transient == $past(sample_bit), "transient level does not follow the sample")
  `PSD_ASSERT_NEXT(a_hit_moves_stable, clk, rst, update && res.hit, stable != $past(stable), "edge reported without a stable level change")
  `PSD_ASSERT_ALWAYS(a_level_needs_hit, clk, rst, !res.level || res.hit, "level without an edge")

endmodule

// ===== rtl/psd_merge.sv =====
// Merges the lane results into one result word held in the output register.
module psd_merge
  import psd_pkg::*;
#(
  parameter int PIN_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  psd_lane_res_t         lane_res [PIN_COUNT],
  input  logic [PORT_WIDTH-1:0] port_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PORT_WIDTH-1:0] event_mask,
  output logic [PORT_WIDTH-1:0] level_mask,
  output logic [PORT_WIDTH-1:0] port_id,
  output logic                  any_high
);

  logic [PORT_WIDTH-1:0] hits;
  logic [PORT_WIDTH-1:0] levels;
  logic [PORT_WIDTH-1:0] stables;
  logic                  take;

  // Gather the lane bits; pins without a lane stay low.
  for (genvar g = 0; g < PORT_WIDTH; g++) begin : g_pin
    if (g < PIN_COUNT) begin : g_used
      assign hits[g]    = lane_res[g].hit;
      assign levels[g]  = lane_res[g].level;
      assign stables[g] = lane_res[g].stable;
    end else begin : g_unused
      assign hits[g]    = 1'b0;
      assign levels[g]  = 1'b0;
      assign stables[g] = 1'b0;
    end
  end

  // The output register frees up as soon as its result is taken.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Result payload is loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (take) begin
      event_mask <= hits;
      level_mask <= levels;
      port_id    <= port_number;
      any_high   <= |stables;
    end
  end

endmodule

// ===== rtl/port_switch_debouncer.sv =====
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle; each pin lane decides combinationally with one
// time subtract and compare against the bounce delay.
// The input side stalls only while a finished result waits on the output side.
// Synchronous reset clears lane levels, change times and output valid, and
// loads the register defaults (bounce delay 50 ms, all masks and port number zero).
`include "assert_macros.svh"

module port_switch_debouncer
  import psd_pkg::*;
#(
  parameter int PIN_COUNT = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PORT_WIDTH-1:0]  sample,
  input  logic [31:0]            now_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PORT_WIDTH-1:0]  event_mask,
  output logic [PORT_WIDTH-1:0]  level_mask,
  output logic [PORT_WIDTH-1:0]  port_id,
  output logic                   any_high
);

  logic [CFG_DATA_W-1:0] bounce_delay;
  logic [PORT_WIDTH-1:0] port_number;
  logic [PORT_WIDTH-1:0] invert_mask;
  logic [PORT_WIDTH-1:0] fast_mask;
  logic [PORT_WIDTH-1:0] skip_rise_mask;
  logic [PORT_WIDTH-1:0] skip_fall_mask;

  logic                  update;
  logic [TIME_BITS-1:0]  now;
  psd_lane_res_t         lane_res [PIN_COUNT];

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_delay   <= BOUNCE_DELAY_RESET;
      port_number    <= '0;
      invert_mask    <= '0;
      fast_mask      <= '0;
      skip_rise_mask <= '0;
      skip_fall_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_BOUNCE_DELAY: bounce_delay   <= cfg_data;
        REG_PORT_NUMBER:  port_number    <= cfg_data[PORT_WIDTH-1:0];
        REG_INVERT_MASK:  invert_mask    <= cfg_data[PORT_WIDTH-1:0];
        REG_FAST_MASK:    fast_mask      <= cfg_data[PORT_WIDTH-1:0];
        REG_SKIP_RISE:    skip_rise_mask <= cfg_data[PORT_WIDTH-1:0];
        REG_SKIP_FALL:    skip_fall_mask <= cfg_data[PORT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The timestamp is taken modulo the configured time width.
  assign now    = TIME_BITS'(now_ms);
  assign update = in_valid && in_ready;

  // One lane per pin.
  for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
    psd_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .update       (update),
      .sample_bit   (sample[g]),
      .now          (now),
      .bounce_delay (bounce_delay),
      .invert       (invert_mask[g]),
      .fast         (fast_mask[g]),
      .skip_rise    (skip_rise_mask[g]),
      .skip_fall    (skip_fall_mask[g]),
      .res          (lane_res[g])
    );
  end

  // Combine the lanes and hold the result until it is transferred.
  psd_merge #(
    .PIN_COUNT(PIN_COUNT)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lane_res    (lane_res),
    .port_number (port_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_mask  (event_mask),
    .level_mask  (level_mask),
    .port_id     (port_id),
    .any_high    (any_high)
  );

  `PSD_ASSERT_NEXT(a_in_gives_out, clk, rst, update, out_valid, "input transfer produced no result")
  `PSD_ASSERT_ALWAYS(a_level_in_event, clk, rst, !out_valid || ((level_mask & ~event_mask) == '0), "level reported for a pin without an event")
  `PSD_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid, "waiting result dropped")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the port switch debouncer with a predictor and scoreboard class.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  // Register indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_SAMPLES = 150;

  // One result of the debouncer as seen on the output channel.
  typedef struct packed {
    logic [PORT_WIDTH-1:0] events;
    logic [PORT_WIDTH-1:0] levels;
    logic [PORT_WIDTH-1:0] port;
    logic                  high;
  } port_report_t;

  // Tracks every pin lane and the register file, and queues the reports they imply.
  class pin_debounce_tracker;
    logic [CFG_DATA_W-1:0] bounce_delay;
    logic [PORT_WIDTH-1:0] port_number;
    logic [PORT_WIDTH-1:0] invert_mask;
    logic [PORT_WIDTH-1:0] fast_mask;
    logic [PORT_WIDTH-1:0] skip_rise;
    logic [PORT_WIDTH-1:0] skip_fall;
    logic [PORT_WIDTH-1:0] stable_lv;
    logic [PORT_WIDTH-1:0] transient_lv;
    logic [31:0]           change_ms [PORT_WIDTH];
    port_report_t          pending_reports [$];
    int                    errors;
    int                    samples_taken;
    int                    edges_reported;

    function void clear();
      bounce_delay = BOUNCE_DELAY_RESET;
      port_number  = '0;
      invert_mask  = '0;
      fast_mask    = '0;
      skip_rise    = '0;
      skip_fall    = '0;
      stable_lv    = '0;
      transient_lv = '0;
      foreach (change_ms[p]) change_ms[p] = '0;
      pending_reports.delete();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BOUNCE_DELAY: bounce_delay = data;
        REG_PORT_NUMBER:  port_number  = data[PORT_WIDTH-1:0];
        REG_INVERT_MASK:  invert_mask  = data[PORT_WIDTH-1:0];
        REG_FAST_MASK:    fast_mask    = data[PORT_WIDTH-1:0];
        REG_SKIP_RISE:    skip_rise    = data[PORT_WIDTH-1:0];
        REG_SKIP_FALL:    skip_fall    = data[PORT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Runs every lane on one accepted sample and queues the resulting report.
    function void take_sample(logic [PORT_WIDTH-1:0] smp, logic [31:0] now);
      logic [PORT_WIDTH-1:0] ev;
      logic [PORT_WIDTH-1:0] lv;
      logic                  tr;
      logic                  rep;
      logic [31:0]           elapsed;
      port_report_t          rpt;
      ev = '0;
      lv = '0;
      for (int p = 0; p < PORT_WIDTH; p++) begin
        tr = transient_lv[p];
        // Outside fast mode a change restarts the lane's timer before the check.
        if (!fast_mask[p] && smp[p] != tr) begin
          transient_lv[p] = smp[p];
          tr = smp[p];
          change_ms[p] = now;
        end
        if (smp[p] != stable_lv[p]) begin
          elapsed = now - change_ms[p];
          if (elapsed > {16'd0, bounce_delay}) begin
            rep = smp[p] ^ invert_mask[p];
            stable_lv[p] = smp[p];
            if (rep) begin
              if (!skip_rise[p]) begin
                ev[p] = 1'b1;
                lv[p] = 1'b1;
              end
            end else if (!skip_fall[p]) begin
              ev[p] = 1'b1;
            end
          end
        end
        if (smp[p] != tr) begin
          transient_lv[p] = smp[p];
          change_ms[p] = now;
        end
      end
      rpt.events = ev;
      rpt.levels = lv;
      rpt.port   = port_number;
      rpt.high   = |stable_lv;
      pending_reports.push_back(rpt);
      samples_taken++;
      edges_reported += $countones(ev);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Compares one transferred report against the oldest pending one.
    function void check_report(port_report_t got);
      port_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: report 0x%0h arrived with no sample pending", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      compare_field("event_mask", want.events, got.events);
      compare_field("level_mask", want.levels, got.levels);
      compare_field("port_id", want.port, got.port);
      compare_field("any_high", want.high, got.high);
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PORT_WIDTH-1:0]  sample = '0;
  logic [31:0]            now_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PORT_WIDTH-1:0]  event_mask;
  logic [PORT_WIDTH-1:0]  level_mask;
  logic [PORT_WIDTH-1:0]  port_id;
  logic                   any_high;

  pin_debounce_tracker tracker = new();

  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  logic                  hold_req = 1'b0;
  int                    hold_left = 0;
  int                    cycle_count = 0;
  logic [31:0]           clock_ms = '0;
  logic [PORT_WIDTH-1:0] intended_levels = '0;

  port_switch_debouncer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_mask (event_mask),
    .level_mask (level_mask),
    .port_id    (port_id),
    .any_high   (any_high)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reports pending", cycle_count,
               tracker.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Both channels are sampled mid-cycle, when they are stable, for the transfer at the
  // next rising edge. The output is checked first, as it always belongs to an older sample.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        tracker.check_report({event_mask, level_mask, port_id, any_high});
      if (in_valid && in_ready)
        tracker.take_sample(sample, now_ms);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    tracker.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Writes the whole register file; the unused upper data bits carry random junk.
  task automatic configure(input logic [15:0] delay, input logic [7:0] port,
                           input logic [7:0] inv, input logic [7:0] fast,
                           input logic [7:0] rise, input logic [7:0] fall);
    write_reg(REG_BOUNCE_DELAY, delay);
    write_reg(REG_PORT_NUMBER, {8'($urandom), port});
    write_reg(REG_INVERT_MASK, {8'($urandom), inv});
    write_reg(REG_FAST_MASK, {8'($urandom), fast});
    write_reg(REG_SKIP_RISE, {8'($urandom), rise});
    write_reg(REG_SKIP_FALL, {8'($urandom), fall});
    cfg_write <= 1'b0;
  endtask

  // Offers one sample, with random idle cycles first, and returns at its transfer edge.
  task automatic send_sample(input logic [PORT_WIDTH-1:0] smp, input logic [31:0] now);
    logic took;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    now_ms   <= now;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Stops offering and waits until every pending report has been transferred.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(99, 0);
    if (r < 25) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Mostly real switch activity: occasional deliberate level changes, contact bounce
  // around them and time steps that straddle the bounce delay; a little pure noise.
  task automatic run_phase(input int n_items);
    logic [PORT_WIDTH-1:0] smp;
    int                    span;
    int                    r;
    span = tracker.bounce_delay;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99, 0);
      if (r < 45)
        clock_ms += $urandom_range(span / 8 + 1, 0);
      else if (r < 85)
        clock_ms += $urandom_range(span + 2, (span > 0) ? span - 1 : 0);
      else if (r < 96)
        clock_ms += $urandom_range(3 * span + 3, 0);
      else
        clock_ms = $urandom;
      r = $urandom_range(99, 0);
      if (r < 20)
        intended_levels ^= 8'(1 << $urandom_range(7, 0));
      else if (r < 28)
        intended_levels = 8'($urandom);
      smp = intended_levels;
      r = $urandom_range(99, 0);
      if (r < 22)
        smp ^= 8'($urandom_range(255, 1));
      else if (r < 27)
        smp = 8'($urandom);
      send_sample(smp, clock_ms);
    end
  endtask

  initial begin
    tracker.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: exact threshold, acceptance after it, and a delay across time wrap.
    send_sample(8'h00, 32'd0);
    send_sample(8'hFF, 32'd10);
    send_sample(8'hFF, 32'd60);
    send_sample(8'hFF, 32'd61);
    send_sample(8'h00, 32'hFFFF_FFF0);
    send_sample(8'h00, 32'h0000_0023);
    send_sample(8'hAA, 32'h0000_0023);
    settle();

    // Writes to unmapped indexes must change nothing; then zero delay with mixed masks.
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'hFFFF);
    configure(16'd0, 8'hA5, 8'hF0, 8'h0F, 8'h33, 8'hCC);
    @(posedge clk);
    send_sample(8'h55, 32'h100);
    send_sample(8'h55, 32'h100);
    send_sample(8'h55, 32'h101);
    send_sample(8'hAA, 32'h101);
    send_sample(8'hFF, 32'h200);
    send_sample(8'h00, 32'h300);
    send_sample(8'h00, 32'h301);
    send_sample(8'hFF, 32'h302);
    settle();

    // Longest delay, every pin inverted, nothing suppressed.
    configure(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
    @(posedge clk);
    send_sample(8'h0F, 32'h1000);
    send_sample(8'h0F, 32'h1000 + 32'd65535);
    send_sample(8'h0F, 32'h1000 + 32'd65536);
    send_sample(8'hF0, 32'hFFFF_FFFF);
    send_sample(8'hF0, 32'h0000_FFFF);
    settle();

    // Random phases, each with its own register settings and one of three idling patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3)
        set_idling(31, 52);
      else if (p < 6)
        set_idling(52, 31);
      else
        set_idling(0, 0);
      case (p % 5)
        0: configure(16'd0, 8'($urandom), pick_mask(), pick_mask(), pick_mask(), pick_mask());
        1: configure(16'hFFFF, 8'($urandom), pick_mask(), pick_mask(), pick_mask(),
                     pick_mask());
        4: configure(16'($urandom), 8'($urandom), pick_mask(), pick_mask(), pick_mask(),
                     pick_mask());
        default: configure(16'($urandom_range(100, 1)), 8'($urandom), pick_mask(),
                           pick_mask(), pick_mask(), pick_mask());
      endcase
      clock_ms = $urandom;
      @(posedge clk);
      // One phase starts with the receiver holding off while samples keep coming.
      if (p == 7) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      run_phase(PHASE_SAMPLES);
      settle();
    end

    $display("Checked %0d samples over %0d random register settings and the directed cases;",
             tracker.samples_taken, NUM_PHASES);
    $display("%0d debounced pin edges were reported and matched.", tracker.edges_reported);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
